[design/fmmn_pkg.sv]
// Shared constants, types and controller/datapath links for the frame min-max normalizer.
`default_nettype none

package fmmn_pkg;

  localparam int MAX_DIM_DEF     = 256;
  localparam int SAMPLE_BITS_DEF = 24;

  // Output pixel word width and scale.
  localparam int PIX_BITS  = 24;
  localparam int QUOT_BITS = 8;                   // scaled range 0..255
  localparam int STEP_BITS = $clog2(QUOT_BITS);

  // Configuration port.
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 9;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_COLUMNS = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_ROWS    = 2'd1;
  localparam logic [CFG_DATA_BITS-1:0]  DIM_RESET         = 9'd256;

  // Item function codes.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EMIT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic load;       // store sample, update extremes
    logic emit;       // read next pixel, advance emit count
    logic setup;      // load divider from read data
    logic div_step;   // one restoring-division step
    logic out_load;   // write output register
  } cmd_t;

  typedef struct packed {
    logic emit_ok;    // frame complete and pixels remain
    logic flat;       // min equals max
    logic last_step;  // divider on its final step
    logic out_free;   // output register can take a word
  } status_t;

endpackage

`default_nettype wire

[design/fmmn_ifs.sv]
// Valid/ready channel interfaces: input items, result words and configuration writes.
`default_nettype none

interface fmmn_in_if #(
  parameter int SAMPLE_BITS = fmmn_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, func, sample, input ready);
  modport sink   (input valid, func, sample, output ready);
endinterface

interface fmmn_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fmmn_pkg::PIX_BITS-1:0] pixel_value;
  logic                                 flat_frame;
  logic                                 last_pixel;

  modport source (output valid, pixel_value, flat_frame, last_pixel, input ready);
  modport sink   (input valid, pixel_value, flat_frame, last_pixel, output ready);
endinterface

interface fmmn_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [fmmn_pkg::CFG_INDEX_BITS-1:0] index;
  logic [fmmn_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/fmmn_ctrl.sv]
// Controller state machine: input handshake and sequencing of read, divide and output.
`default_nettype none

module fmmn_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_func,
  output logic                   in_ready,
  input  wire fmmn_pkg::status_t status,
  output fmmn_pkg::cmd_t         cmd
);

  fmmn_pkg::state_t state;
  fmmn_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fmmn_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fmmn_pkg::ST_IDLE: begin
        if (in_valid && (in_func == fmmn_pkg::FUNC_EMIT) && status.emit_ok) begin
          state_next = fmmn_pkg::ST_SETUP;
        end
      end
      fmmn_pkg::ST_SETUP: begin
        state_next = status.flat ? fmmn_pkg::ST_HOLD : fmmn_pkg::ST_DIV;
      end
      fmmn_pkg::ST_DIV: begin
        if (status.last_step) begin
          state_next = fmmn_pkg::ST_HOLD;
        end
      end
      fmmn_pkg::ST_HOLD: begin
        if (status.out_free) begin
          state_next = fmmn_pkg::ST_IDLE;
        end
      end
      default: state_next = fmmn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state == fmmn_pkg::ST_IDLE);
    cmd.load     = in_ready && in_valid && (in_func == fmmn_pkg::FUNC_LOAD);
    cmd.emit     = in_ready && in_valid && (in_func == fmmn_pkg::FUNC_EMIT) && status.emit_ok;
    cmd.setup    = (state == fmmn_pkg::ST_SETUP);
    cmd.div_step = (state == fmmn_pkg::ST_DIV);
    cmd.out_load = (state == fmmn_pkg::ST_HOLD) && status.out_free;
  end

endmodule

`default_nettype wire

[design/fmmn_dp.sv]
// Datapath: config registers, frame store, running extremes, counters, divider, output register.
`default_nettype none

module fmmn_dp #(
  parameter int MAX_DIM     = fmmn_pkg::MAX_DIM_DEF,
  parameter int SAMPLE_BITS = fmmn_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire fmmn_pkg::cmd_t                cmd,
  output fmmn_pkg::status_t                  status,
  fmmn_cfg_if.sink                           cfg,
  fmmn_out_if.source                         result
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DIMW  = $clog2(MAX_DIM + 1);
  localparam int CMPW  = (DIMW > fmmn_pkg::CFG_DATA_BITS) ? DIMW : fmmn_pkg::CFG_DATA_BITS;
  localparam int XW    = SAMPLE_BITS + 1;
  localparam int NW    = SAMPLE_BITS + fmmn_pkg::QUOT_BITS;

  // Configuration registers
  logic [fmmn_pkg::CFG_DATA_BITS-1:0] frame_columns;
  logic [fmmn_pkg::CFG_DATA_BITS-1:0] frame_rows;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_columns <= fmmn_pkg::DIM_RESET;
      frame_rows    <= fmmn_pkg::DIM_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == fmmn_pkg::REG_FRAME_COLUMNS) begin
        frame_columns <= cfg.data;
      end else if (cfg.index == fmmn_pkg::REG_FRAME_ROWS) begin
        frame_rows <= cfg.data;
      end
    end
  end

  // Clamp dimensions to 1..MAX_DIM, frame length is their product
  logic [CMPW-1:0] cols_c;
  logic [CMPW-1:0] rows_c;
  logic [CW-1:0]   total;

  always_comb begin
    cols_c = CMPW'(frame_columns);
    rows_c = CMPW'(frame_rows);
    if (cols_c == '0) begin
      cols_c = CMPW'(1);
    end else if (cols_c > CMPW'(MAX_DIM)) begin
      cols_c = CMPW'(MAX_DIM);
    end
    if (rows_c == '0) begin
      rows_c = CMPW'(1);
    end else if (rows_c > CMPW'(MAX_DIM)) begin
      rows_c = CMPW'(MAX_DIM);
    end
    total = CW'(cols_c) * CW'(rows_c);
  end

  // Counters and running extremes
  logic [CW-1:0]                 load_count;
  logic [CW-1:0]                 emit_count;
  logic signed [SAMPLE_BITS-1:0] run_min;
  logic signed [SAMPLE_BITS-1:0] run_max;
  logic                          wrap;
  logic [CW-1:0]                 waddr;

  assign wrap  = (load_count >= total);
  assign waddr = wrap ? '0 : load_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      emit_count <= '0;
      run_min    <= '0;
      run_max    <= '0;
    end else if (cmd.load) begin
      load_count <= waddr + CW'(1);
      if (wrap) begin
        emit_count <= '0;
      end
      if (waddr == '0) begin
        run_min <= sample;
        run_max <= sample;
      end else begin
        if (sample > run_max) run_max <= sample;
        if (sample < run_min) run_min <= sample;
      end
    end else if (cmd.emit) begin
      emit_count <= emit_count + CW'(1);
    end
  end

  // Frame store, one port: write on load, registered read on emit
  logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[waddr[AW-1:0]] <= sample;
    end
    if (cmd.emit) begin
      rd_data <= mem[emit_count[AW-1:0]];
    end
  end

  logic last_reg;

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      last_reg <= (emit_count == (total - CW'(1)));
    end
  end

  // Restoring divider: 255*(x-min) / (max-min), one quotient bit per step
  logic signed [XW-1:0]          diff_x;
  logic signed [XW-1:0]          diff_r;
  logic [NW-1:0]                 num;
  logic [NW-1:0]                 rem;
  logic [NW-1:0]                 dsh;
  logic [fmmn_pkg::QUOT_BITS-1:0] quot;
  logic [fmmn_pkg::STEP_BITS-1:0] step;
  logic                          flat_reg;
  logic                          is_flat;

  assign is_flat = (run_min == run_max);
  assign diff_x  = XW'(rd_data) - XW'(run_min);
  assign diff_r  = XW'(run_max) - XW'(run_min);
  assign num     = (NW'(diff_x[SAMPLE_BITS-1:0]) << fmmn_pkg::QUOT_BITS)
                   - NW'(diff_x[SAMPLE_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      rem      <= num;
      dsh      <= NW'(diff_r[SAMPLE_BITS-1:0]) << (fmmn_pkg::QUOT_BITS - 1);
      quot     <= '0;
      step     <= fmmn_pkg::STEP_BITS'(fmmn_pkg::QUOT_BITS - 1);
      flat_reg <= is_flat;
    end else if (cmd.div_step) begin
      if (rem >= dsh) begin
        rem  <= rem - dsh;
        quot <= {quot[fmmn_pkg::QUOT_BITS-2:0], 1'b1};
      end else begin
        quot <= {quot[fmmn_pkg::QUOT_BITS-2:0], 1'b0};
      end
      dsh  <= dsh >> 1;
      step <= step - fmmn_pkg::STEP_BITS'(1);
    end
  end

  // Output register
  logic out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.pixel_value <= flat_reg ? fmmn_pkg::PIX_BITS'(rd_data)
                                     : fmmn_pkg::PIX_BITS'(quot);
      result.flat_frame  <= flat_reg;
      result.last_pixel  <= last_reg;
    end
  end

  assign result.valid = out_valid;

  always_comb begin
    status.emit_ok   = (load_count >= total) && (emit_count < total);
    status.flat      = is_flat;
    status.last_step = (step == '0);
    status.out_free  = !out_valid || result.ready;
  end

  a_emit_written: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (emit_count < load_count))
    else $error("emit reads a store entry not loaded in this frame");

  a_emit_le_load: assert property (@(posedge clk) disable iff (rst)
    emit_count <= load_count)
    else $error("emit count ran past load count");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (rem < (dsh << 1)))
    else $error("divider remainder out of range, quotient would overflow");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || result.ready))
    else $error("output word overwritten while still waiting");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.setup || cmd.div_step) |-> !cmd.load && !cmd.emit)
    else $error("item taken while a pixel is in the divider");

endmodule

`default_nettype wire

[design/frame_min_max_normalizer_unit.sv]
// Top level of the frame min-max normalizer: controller plus datapath.
//
// Channels (valid/ready, a word moves when both are high on a rising edge):
//   item   - func/sample. func 0 loads one sample of the frame in raster
//            order; func 1 asks for the next pixel scaled to 0..255 (raw if flat).
//   result - pixel_value/flat_frame/last_pixel, one word per granted request.
//   cfg    - register writes: index 0 frame_columns, 1 frame_rows (both reset
//            to 256, 0 reads as 1, above MAX_DIM reads as MAX_DIM). Other
//            indexes are dropped. cfg.ready is always high.
// Throughput: loads go in at one per cycle while no pixel request is in
//   progress. A request that finds the frame complete and a pixel left
//   holds off the next item until it is done: the frame store is read, the
//   divider is set up, eight steps of the restoring divider run (one
//   quotient bit each), and the output register is written. A flat frame
//   skips the divider. Requests that find no pixel due give no word.
// Stall: the output register holds a finished word; the next item is still
//   taken, and a new pixel waits in the hold state until that word leaves.
// Reset (rst, synchronous): counts, extremes and config go to their reset
//   values; the frame store is not cleared, no pixel is read before loading.
`default_nettype none

module frame_min_max_normalizer_unit #(
  parameter int MAX_DIM     = fmmn_pkg::MAX_DIM_DEF,
  parameter int SAMPLE_BITS = fmmn_pkg::SAMPLE_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  fmmn_in_if.sink    item,
  fmmn_out_if.source result,
  fmmn_cfg_if.sink   cfg
);

  fmmn_pkg::cmd_t    cmd;
  fmmn_pkg::status_t status;
  logic              in_ready;

  assign item.ready = in_ready;

  fmmn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_func  (item.func),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  fmmn_dp #(
    .MAX_DIM     (MAX_DIM),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .sample (SAMPLE_BITS'(item.sample)),
    .cmd    (cmd),
    .status (status),
    .cfg    (cfg),
    .result (result)
  );

endmodule

`default_nettype wire
